>>> rtl/dap_pkg.sv
// Shared types, constants and helpers for the degenerate anchoring projection.
// Holds fixed-point widths, index tables, pipeline depths and payload structs.
// No dependencies; every other file of the block imports this package.
package dap_pkg;

    // Fixed-point format
    localparam int DEF_FRAC_BITS = 20;
    localparam int FIELD_W       = 24;
    localparam int MID_W         = 28;
    localparam int S_W           = 23;
    localparam int T_W           = 27;
    localparam int ACC_W         = 64;
    localparam int DIV9_W        = 30;
    localparam int DIV9_SHIFT    = 33;

    localparam int NUM_Q = 6;
    localparam int NUM_N = 3;

    // Pipeline depth of each segment
    localparam int FRONT_STAGES = 3;
    localparam int QUAD_STAGES  = 3;
    localparam int SCALE_STAGES = 4;
    localparam int PIPE_DEPTH   = FRONT_STAGES + QUAD_STAGES + SCALE_STAGES;

    typedef logic signed [FIELD_W-1:0]          field_t;
    typedef logic signed [MID_W-1:0]            mid_t;
    typedef logic        [S_W-1:0]              order_t;
    typedef logic signed [T_W-1:0]              tens_t;
    typedef logic signed [T_W+FIELD_W-1:0]      tprod_t;
    typedef logic signed [2*FIELD_W-1:0]        nprod_t;
    typedef logic signed [MID_W+FIELD_W-1:0]    vprod_t;
    typedef logic signed [MID_W+FIELD_W:0]      cross_t;
    typedef logic signed [ACC_W-1:0]            acc_t;
    typedef logic        [MID_W-1:0]            zbias_t;
    typedef logic        [MID_W+DIV9_W-1:0]     qprod_t;

    localparam order_t S_RESET = order_t'(524288);

    // Upper-triangle order: xx xy xz yy yz zz
    localparam int ROW [NUM_Q] = '{0, 0, 0, 1, 1, 2};
    localparam int COL [NUM_Q] = '{0, 1, 2, 1, 2, 2};
    localparam int SYM_IDX [NUM_N][NUM_N] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

    // Saturation bounds
    localparam acc_t MID_MAX   = (acc_t'(1) <<< (MID_W - 1)) - acc_t'(1);
    localparam acc_t MID_MIN   = -(acc_t'(1) <<< (MID_W - 1));
    localparam acc_t FIELD_MAX = (acc_t'(1) <<< (FIELD_W - 1)) - acc_t'(1);
    localparam acc_t FIELD_MIN = -(acc_t'(1) <<< (FIELD_W - 1));

    // Divide by nine: clamp to the span that maps onto the output range,
    // bias to unsigned, multiply by a reciprocal exact below 2^33
    localparam acc_t   ZBIAS    = acc_t'(9) <<< (FIELD_W - 1);
    localparam acc_t   CLAMP_HI = ZBIAS - acc_t'(1);
    localparam acc_t   CLAMP_LO = -ZBIAS;
    localparam acc_t   ZP_TOP   = (ZBIAS <<< 1) - acc_t'(1);
    localparam zbias_t ZP_MAX   = ZP_TOP[MID_W-1:0];
    localparam logic [ACC_W-1:0] DIV9_FULL = ((64'd1 << DIV9_SHIFT) + 64'd1) / 64'd9;
    localparam logic [DIV9_W-1:0] DIV9_MUL = DIV9_FULL[DIV9_W-1:0];

    // Payload of one input beat
    typedef struct packed {
        field_t [NUM_Q-1:0] q;
        field_t [NUM_N-1:0] n;
    } dap_item_t;

    // After the front segment: 3*Qt n and n n^T
    typedef struct packed {
        mid_t   [NUM_N-1:0] v3;
        field_t [NUM_Q-1:0] m;
        field_t [NUM_N-1:0] n;
    } dap_front_t;

    // After the quadratic segment: cross sums, s3*m and s3
    typedef struct packed {
        cross_t [NUM_Q-1:0] a;
        vprod_t [NUM_Q-1:0] sm;
        mid_t               s3;
    } dap_quad_t;

    // Payload of one output beat
    typedef struct packed {
        field_t [NUM_Q-1:0] d;
    } dap_result_t;

    // Round to nearest, ties up, dropping frac fraction bits
    function automatic acc_t round_frac(input acc_t x, input int frac);
        return (x + (acc_t'(1) <<< (frac - 1))) >>> frac;
    endfunction

    function automatic mid_t sat_mid(input acc_t x);
        mid_t r;
        if (x > MID_MAX)
            r = MID_MAX[MID_W-1:0];
        else if (x < MID_MIN)
            r = MID_MIN[MID_W-1:0];
        else
            r = x[MID_W-1:0];
        return r;
    endfunction

    function automatic field_t sat_field(input acc_t x);
        field_t r;
        if (x > FIELD_MAX)
            r = FIELD_MAX[FIELD_W-1:0];
        else if (x < FIELD_MIN)
            r = FIELD_MIN[FIELD_W-1:0];
        else
            r = x[FIELD_W-1:0];
        return r;
    endfunction

endpackage

>>> rtl/dap_if.sv
// Stream interfaces for the input and result channels of the projection block.
// Depends on dap_pkg for the field type.
interface dap_in_if import dap_pkg::*;;
    logic   valid;
    logic   ready;
    field_t q_xx;
    field_t q_xy;
    field_t q_xz;
    field_t q_yy;
    field_t q_yz;
    field_t q_zz;
    field_t normal_x;
    field_t normal_y;
    field_t normal_z;

    modport source (
        output valid, q_xx, q_xy, q_xz, q_yy, q_yz, q_zz,
               normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, q_xx, q_xy, q_xz, q_yy, q_yz, q_zz,
               normal_x, normal_y, normal_z,
        output ready
    );
endinterface

interface dap_out_if import dap_pkg::*;;
    logic   valid;
    logic   ready;
    field_t diff_xx;
    field_t diff_xy;
    field_t diff_xz;
    field_t diff_yy;
    field_t diff_yz;
    field_t diff_zz;

    modport source (
        output valid, diff_xx, diff_xy, diff_xz, diff_yy, diff_yz, diff_zz,
        input  ready
    );
    modport sink (
        input  valid, diff_xx, diff_xy, diff_xz, diff_yy, diff_yz, diff_zz,
        output ready
    );
endinterface

>>> rtl/dap_front.sv
// Front pipeline segment: forms 3*Qt, then 3*Qt n and n n^T, three stages.
// Depends on dap_pkg.
module dap_front import dap_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  order_t     order_parameter,
    input  logic       up_valid,
    output logic       up_ready,
    input  dap_item_t  up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output dap_front_t dn_data
);

    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] vld_next;
    logic [FRONT_STAGES:0]   adv;

    tens_t  t_next  [NUM_Q];
    tens_t  t_reg   [NUM_Q];
    field_t n1_reg  [NUM_N];
    tprod_t tp_next [NUM_N][NUM_N];
    tprod_t tp_reg  [NUM_N][NUM_N];
    nprod_t np_next [NUM_Q];
    nprod_t np_reg  [NUM_Q];
    field_t n2_reg  [NUM_N];
    mid_t   v3_next [NUM_N];
    mid_t   v3_reg  [NUM_N];
    field_t m_next  [NUM_Q];
    field_t m_reg   [NUM_Q];
    field_t n3_reg  [NUM_N];
    tens_t  s_ext;

    // Stage advance: a stage moves when empty or when the next one moves
    always_comb
    begin
        adv[FRONT_STAGES] = dn_ready;
        for (int k = FRONT_STAGES - 1; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    assign vld_next = (adv[FRONT_STAGES-1:0] & {vld_reg[FRONT_STAGES-2:0], up_valid})
                    | (~adv[FRONT_STAGES-1:0] & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign up_ready = adv[0];
    assign dn_valid = vld_reg[FRONT_STAGES-1];

    // Stage 1: T = 3*Q + S on the diagonal
    assign s_ext = tens_t'(order_parameter);

    always_comb
    begin
        for (int k = 0; k < NUM_Q; k++)
        begin
            t_next[k] = (tens_t'(up_data.q[k]) <<< 1) + tens_t'(up_data.q[k]);
            if (ROW[k] == COL[k])
                t_next[k] = t_next[k] + s_ext;
        end
    end

    // Stage 2: products T_ij*n_j and n_i*n_j
    always_comb
    begin
        for (int i = 0; i < NUM_N; i++)
            for (int j = 0; j < NUM_N; j++)
                tp_next[i][j] = tprod_t'(t_reg[SYM_IDX[i][j]]) * tprod_t'(n1_reg[j]);
        for (int k = 0; k < NUM_Q; k++)
            np_next[k] = nprod_t'(n1_reg[ROW[k]]) * nprod_t'(n1_reg[COL[k]]);
    end

    // Stage 3: row sums, rounding and saturation
    always_comb
    begin
        for (int i = 0; i < NUM_N; i++)
            v3_next[i] = sat_mid(round_frac(acc_t'(tp_reg[i][0]) + acc_t'(tp_reg[i][1])
                                            + acc_t'(tp_reg[i][2]), FRAC_BITS));
        for (int k = 0; k < NUM_Q; k++)
            m_next[k] = sat_field(round_frac(acc_t'(np_reg[k]), FRAC_BITS));
    end

    // Data registers, loaded when their stage advances
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            t_reg <= t_next;
            for (int j = 0; j < NUM_N; j++)
                n1_reg[j] <= up_data.n[j];
        end
        if (adv[1])
        begin
            tp_reg <= tp_next;
            np_reg <= np_next;
            n2_reg <= n1_reg;
        end
        if (adv[2])
        begin
            v3_reg <= v3_next;
            m_reg  <= m_next;
            n3_reg <= n2_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_N; i++)
        begin
            dn_data.v3[i] = v3_reg[i];
            dn_data.n[i]  = n3_reg[i];
        end
        for (int k = 0; k < NUM_Q; k++)
            dn_data.m[k] = m_reg[k];
    end

endmodule

>>> rtl/dap_quad.sv
// Quadratic pipeline segment: n v^T products, s3 = n.(3Qt n) and s3 * n n^T.
// Three stages. Depends on dap_pkg.
module dap_quad import dap_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  dap_front_t up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output dap_quad_t  dn_data
);

    logic [QUAD_STAGES-1:0] vld_reg;
    logic [QUAD_STAGES-1:0] vld_next;
    logic [QUAD_STAGES:0]   adv;

    vprod_t p_next  [NUM_N][NUM_N];
    vprod_t p_reg   [NUM_N][NUM_N];
    field_t m4_reg  [NUM_Q];
    mid_t   s3_next;
    mid_t   s3_reg;
    cross_t a_next  [NUM_Q];
    cross_t a_reg   [NUM_Q];
    field_t m5_reg  [NUM_Q];
    vprod_t sm_next [NUM_Q];
    vprod_t sm_reg  [NUM_Q];
    cross_t a6_reg  [NUM_Q];
    mid_t   s36_reg;

    // Stage advance
    always_comb
    begin
        adv[QUAD_STAGES] = dn_ready;
        for (int k = QUAD_STAGES - 1; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    assign vld_next = (adv[QUAD_STAGES-1:0] & {vld_reg[QUAD_STAGES-2:0], up_valid})
                    | (~adv[QUAD_STAGES-1:0] & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign up_ready = adv[0];
    assign dn_valid = vld_reg[QUAD_STAGES-1];

    // Stage 4: all nine n_i * v3_j
    always_comb
    begin
        for (int i = 0; i < NUM_N; i++)
            for (int j = 0; j < NUM_N; j++)
                p_next[i][j] = vprod_t'(up_data.n[i]) * vprod_t'(up_data.v3[j]);
    end

    // Stage 5: s3 from the diagonal, symmetric cross sums
    always_comb
    begin
        s3_next = sat_mid(round_frac(acc_t'(p_reg[0][0]) + acc_t'(p_reg[1][1])
                                     + acc_t'(p_reg[2][2]), FRAC_BITS));
        for (int k = 0; k < NUM_Q; k++)
            a_next[k] = cross_t'(p_reg[ROW[k]][COL[k]]) + cross_t'(p_reg[COL[k]][ROW[k]]);
    end

    // Stage 6: s3 * m
    always_comb
    begin
        for (int k = 0; k < NUM_Q; k++)
            sm_next[k] = vprod_t'(s3_reg) * vprod_t'(m5_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            p_reg <= p_next;
            for (int k = 0; k < NUM_Q; k++)
                m4_reg[k] <= up_data.m[k];
        end
        if (adv[1])
        begin
            s3_reg <= s3_next;
            a_reg  <= a_next;
            m5_reg <= m4_reg;
        end
        if (adv[2])
        begin
            sm_reg  <= sm_next;
            a6_reg  <= a_reg;
            s36_reg <= s3_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_Q; k++)
        begin
            dn_data.a[k]  = a6_reg[k];
            dn_data.sm[k] = sm_reg[k];
        end
        dn_data.s3 = s36_reg;
    end

endmodule

>>> rtl/dap_scale.sv
// Output pipeline segment: assembles 3*residual, rounds, divides by nine and
// saturates; four stages, the last one is the output register. Depends on dap_pkg.
module dap_scale import dap_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  dap_quad_t   up_data,
    output logic        dn_valid,
    input  logic        dn_ready,
    output dap_result_t dn_data
);

    localparam acc_t DIV_ROUND = acc_t'(9) <<< (FRAC_BITS - 1);

    logic [SCALE_STAGES-1:0] vld_reg;
    logic [SCALE_STAGES-1:0] vld_next;
    logic [SCALE_STAGES:0]   adv;

    acc_t   y_next  [NUM_Q];
    acc_t   y_reg   [NUM_Q];
    zbias_t zp_next [NUM_Q];
    zbias_t zp_reg  [NUM_Q];
    qprod_t qp_next [NUM_Q];
    qprod_t qp_reg  [NUM_Q];
    field_t d_next  [NUM_Q];
    field_t d_reg   [NUM_Q];

    // Stage advance
    always_comb
    begin
        adv[SCALE_STAGES] = dn_ready;
        for (int k = SCALE_STAGES - 1; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    assign vld_next = (adv[SCALE_STAGES-1:0] & {vld_reg[SCALE_STAGES-2:0], up_valid})
                    | (~adv[SCALE_STAGES-1:0] & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign up_ready = adv[0];
    assign dn_valid = vld_reg[SCALE_STAGES-1];

    // Stage 7: Y = 3*(a - s3*m), less s3 * one on the diagonal
    always_comb
    begin
        acc_t diff;
        for (int k = 0; k < NUM_Q; k++)
        begin
            diff      = acc_t'(up_data.a[k]) - acc_t'(up_data.sm[k]);
            y_next[k] = (diff <<< 1) + diff;
            if (ROW[k] == COL[k])
                y_next[k] = y_next[k] - (acc_t'(up_data.s3) <<< FRAC_BITS);
        end
    end

    // Stage 8: drop fraction bits, clamp to the output span, bias to unsigned
    always_comb
    begin
        acc_t z;
        acc_t zb;
        for (int k = 0; k < NUM_Q; k++)
        begin
            z  = (y_reg[k] + DIV_ROUND) >>> FRAC_BITS;
            zb = z + ZBIAS;
            if (z > CLAMP_HI)
                zp_next[k] = ZP_MAX;
            else if (z < CLAMP_LO)
                zp_next[k] = '0;
            else
                zp_next[k] = zb[MID_W-1:0];
        end
    end

    // Stage 9: reciprocal multiply for the divide by nine
    always_comb
    begin
        for (int k = 0; k < NUM_Q; k++)
            qp_next[k] = qprod_t'(zp_reg[k]) * qprod_t'(DIV9_MUL);
    end

    // Stage 10: quotient less the bias is the quotient with its top bit flipped
    always_comb
    begin
        for (int k = 0; k < NUM_Q; k++)
            d_next[k] = {~qp_reg[k][DIV9_SHIFT+FIELD_W-1],
                         qp_reg[k][DIV9_SHIFT+FIELD_W-2:DIV9_SHIFT]};
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            y_reg <= y_next;
        if (adv[1])
            zp_reg <= zp_next;
        if (adv[2])
            qp_reg <= qp_next;
        if (adv[3])
            d_reg <= d_next;
    end

    always_comb
    begin
        for (int k = 0; k < NUM_Q; k++)
            dn_data.d[k] = d_reg[k];
    end

endmodule

>>> rtl/degenerate_anchoring_projection.sv
// Top level of the degenerate anchoring projection residual pipeline.
// Depends on dap_pkg, dap_if (dap_in_if, dap_out_if), dap_front, dap_quad, dap_scale.
//
// Usage:
//   item   : valid/ready stream carrying Q (six upper-triangle entries) and
//            the surface normal n; a beat moves when valid and ready are high.
//   result : valid/ready stream carrying the six saturated residual entries
//            Qt - P Qt P, with n.Qt.n/3 taken off the diagonal.
//   cfg_we / cfg_wdata : writes the order parameter S; write only while idle.
// Each accepted item beat passes ten register stages (3 front, 3 quadratic,
// 4 scaling) to its result beat. Throughput is one beat per cycle while the
// receiver takes results; no stage holds more than a 24x28-class multiplier or
// one wide add and compare. A stalled receiver holds the output register; stages
// behind it keep filling bubbles, so the input stays ready until all ten
// stages hold data. Reset empties the pipeline and sets S to 0.5.
module degenerate_anchoring_projection import dap_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  order_t    cfg_wdata,
    dap_in_if.sink    item,
    dap_out_if.source result
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    order_t      order_reg;
    dap_item_t   item_data;
    dap_front_t  front_data;
    dap_quad_t   quad_data;
    dap_result_t res_data;
    logic        front_valid;
    logic        front_ready;
    logic        quad_valid;
    logic        quad_ready;
    logic [CNT_W-1:0] in_flight_reg;
    logic [CNT_W-1:0] in_flight_next;

    // Order parameter register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= S_RESET;
        else if (cfg_we)
            order_reg <= cfg_wdata;
    end

    // Input beat packing
    assign item_data.q[0] = item.q_xx;
    assign item_data.q[1] = item.q_xy;
    assign item_data.q[2] = item.q_xz;
    assign item_data.q[3] = item.q_yy;
    assign item_data.q[4] = item.q_yz;
    assign item_data.q[5] = item.q_zz;
    assign item_data.n[0] = item.normal_x;
    assign item_data.n[1] = item.normal_y;
    assign item_data.n[2] = item.normal_z;

    dap_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .order_parameter (order_reg),
        .up_valid        (item.valid),
        .up_ready        (item.ready),
        .up_data         (item_data),
        .dn_valid        (front_valid),
        .dn_ready        (front_ready),
        .dn_data         (front_data)
    );

    dap_quad #(.FRAC_BITS(FRAC_BITS)) u_quad (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (front_valid),
        .up_ready (front_ready),
        .up_data  (front_data),
        .dn_valid (quad_valid),
        .dn_ready (quad_ready),
        .dn_data  (quad_data)
    );

    dap_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (quad_valid),
        .up_ready (quad_ready),
        .up_data  (quad_data),
        .dn_valid (result.valid),
        .dn_ready (result.ready),
        .dn_data  (res_data)
    );

    // Result beat unpacking
    assign result.diff_xx = res_data.d[0];
    assign result.diff_xy = res_data.d[1];
    assign result.diff_xz = res_data.d[2];
    assign result.diff_yy = res_data.d[3];
    assign result.diff_yz = res_data.d[4];
    assign result.diff_zz = res_data.d[5];

    // Occupancy count: beats accepted and not yet delivered
    always_comb
    begin
        case ({item.valid && item.ready, result.valid && result.ready})
            2'b10:   in_flight_next = in_flight_reg + CNT_W'(1);
            2'b01:   in_flight_next = in_flight_reg - CNT_W'(1);
            default: in_flight_next = in_flight_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_flight_reg <= '0;
        else
            in_flight_reg <= in_flight_next;
    end

    // Never more beats in flight than register stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg <= CNT_W'(PIPE_DEPTH))
        else $error("pipeline holds more beats than stages");

    // No result without an accepted item behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (in_flight_reg == '0) |-> !result.valid)
        else $error("result valid with empty pipeline");

    // Input only backs up when the output is stalled
    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (result.valid && !result.ready))
        else $error("input stalled while output is free");

    // A full pipeline with a stalled receiver refuses input
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        ((in_flight_reg == CNT_W'(PIPE_DEPTH)) && !result.ready) |-> !item.ready)
        else $error("input accepted into a full pipeline");

endmodule
